@@ rtl/cube_sphere_vertex_generator_unit_defines.svh @@
// Assertion macros shared by the cube-sphere vertex generator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CUBE_SPHERE_VERTEX_GENERATOR_UNIT_DEFINES_SVH
`define CUBE_SPHERE_VERTEX_GENERATOR_UNIT_DEFINES_SVH

// A condition that must hold at every rising clock edge outside reset.
`define CSV_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define CSV_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/csv_pkg.sv @@
// Types, widths and helper functions of the cube-sphere vertex generator.
// No dependencies; used by the generator top, csv_front, csv_back and the testbench.
package csv_pkg;

    localparam int MAX_SUBDIVISIONS = 256;
    localparam int COORD_FRAC_BITS = 15;
    localparam int S_W    = 9;
    localparam int FACE_W = 3;
    localparam int MAG_W  = 9;
    localparam int LEN_W  = 20;
    localparam int W_W    = COORD_FRAC_BITS + 2;
    localparam int SHIFT  = 2 * COORD_FRAC_BITS + 2;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int REM_W  = SQ_W + SHIFT;
    localparam int M_W    = W_W + LEN_W;
    localparam int TERM_W = M_W + W_W + 4;
    localparam int IDX_W  = 19;
    localparam int POS_W  = 16;
    localparam int FR_W   = 12;
    localparam int BASE_W = FR_W + S_W + 1;

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_NEG_Y = 3'd2,
        FACE_POS_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } csv_face_e;

    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic [S_W-1:0]    row;
        logic [S_W-1:0]    col;
    } csv_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        base_index;
        logic [IDX_W-1:0]        below_index;
        logic [IDX_W-1:0]        right_index;
        logic [IDX_W-1:0]        diagonal_index;
        logic                    quad_valid;
    } csv_out_t;

    typedef struct packed {
        logic [S_W-1:0] subdivisions;
    } csv_cfg_t;

    // Everything but the coordinates, carried alongside the normaliser.
    typedef struct packed {
        logic [2:0]       neg;
        logic [LEN_W-1:0] len2;
        logic [IDX_W-1:0] base_index;
        logic [IDX_W-1:0] below_index;
        logic [IDX_W-1:0] right_index;
        logic [IDX_W-1:0] diagonal_index;
        logic             quad_valid;
    } csv_meta_t;

    // Classified vertex handed from the front end to the back end.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        csv_meta_t             meta;
    } csv_work_t;

    // Partial root of one component: remainder, w*len2 and w so far.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [M_W-1:0]   m;
        logic [W_W-1:0]   w;
    } csv_acc_t;

    typedef struct packed {
        csv_acc_t [2:0] acc;
        csv_meta_t      meta;
    } csv_stage_t;

    // One bit of w, the largest value with w*w*len2 <= a*a*2^SHIFT.
    function automatic csv_acc_t csv_root_step(csv_acc_t a, logic [LEN_W-1:0] len2,
                                               int unsigned j);
        logic [TERM_W-1:0] add;
        logic [TERM_W-1:0] term;
        csv_acc_t          r;
        add  = TERM_W'(len2) << j;
        term = ((TERM_W'(a.m) << 1) + add) << j;
        r    = a;
        if (term <= TERM_W'(a.rem))
        begin
            r.rem = REM_W'(TERM_W'(a.rem) - term);
            r.m   = M_W'(TERM_W'(a.m) + add);
            r.w   = a.w | (W_W'(1) << j);
        end
        return r;
    endfunction

    // Rounded magnitude from w, then sign and saturation to Q1.15.
    function automatic logic signed [POS_W-1:0] csv_to_coord(logic [W_W-1:0] w, logic neg);
        logic [W_W:0]     wr;
        logic [POS_W-1:0] mag;
        wr  = ({1'b0, w} + (W_W+1)'(1)) >> 1;
        mag = POS_W'(wr);
        if (neg)
            return POS_W'(-mag);
        else if (mag[POS_W-1])
            return {1'b0, {(POS_W-1){1'b1}}};
        else
            return mag;
    endfunction

endpackage

@@ rtl/csv_stream_if.sv @@
// Valid/ready channel carrying one payload beat per handshake.
// Depends on nothing; the payload type is a parameter.
interface csv_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/cube_sphere_vertex_generator_unit.sv @@
// Cube-sphere vertex generator: one grid point in, one unit-length vertex
// with its index and quad neighbours out, every cycle unless the result
// channel stalls. A front end clamps the beat into one register stage and
// forms the face vector, squared length and indices on the way into a
// four-entry queue that decouples it from the back end, and the back end
// finds each coordinate with a 17-stage square-root pipeline that settles
// one root bit per stage. Throughput is one vertex per clock while the
// result channel is not stalled. Subdivision writes must be made while idle.
// Depends on csv_pkg, csv_stream_if, csv_fifo, csv_front and csv_back.
module cube_sphere_vertex_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    csv_stream_if.sink   item,
    csv_stream_if.sink   cfg,
    csv_stream_if.source result
);
    import csv_pkg::*;

    logic      push, full, pop, empty;
    csv_work_t push_data, pop_data;

    // Classification front end.
    csv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Decoupling queue.
    csv_fifo #(
        .T     (csv_work_t),
        .DEPTH (4)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Normalising back end.
    csv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty),
        .result   (result)
    );
endmodule

@@ rtl/csv_fifo.sv @@
// Small register-based queue between the front and back ends.
// Depends on the assertion macros header.
`include "cube_sphere_vertex_generator_unit_defines.svh"

module csv_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     push_data,
    output logic full,
    input  logic pop,
    output T     pop_data,
    output logic empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Storage is written without reset.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `CSV_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full || pop, "push into a full queue")
    `CSV_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !empty, "pop from an empty queue")
endmodule

@@ rtl/csv_front.sv @@
// Front end: takes vertex beats, clamps them, forms the face vector and indices.
// Depends on csv_pkg and csv_stream_if.
module csv_front (
    input  logic                clk,
    input  logic                rst_n,
    csv_stream_if.sink          item,
    csv_stream_if.sink          cfg,
    output logic                push,
    output csv_pkg::csv_work_t  push_data,
    input  logic                full
);
    import csv_pkg::*;

    logic [S_W-1:0]    subdivisions_reg;
    logic              v1_reg;
    logic [S_W-1:0]    s1_reg, row1_reg, col1_reg;
    logic [FACE_W-1:0] face1_reg;
    logic [FR_W-1:0]   fr1_reg;

    logic [S_W-1:0]    s_eff, row_c, col_c;
    logic [FACE_W-1:0] face_c;
    logic              take;

    // Configuration register, always ready.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            subdivisions_reg <= S_W'(16);
        else if (cfg.valid)
            subdivisions_reg <= cfg.data.subdivisions;
    end

    // Clamp the subdivision count, face, row and column.
    always_comb
    begin
        if (subdivisions_reg == '0)
            s_eff = S_W'(1);
        else if (32'(subdivisions_reg) > MAX_SUBDIVISIONS)
            s_eff = S_W'(MAX_SUBDIVISIONS);
        else
            s_eff = subdivisions_reg;
        face_c = (item.data.face > FACE_NEG_Z) ? FACE_NEG_Z : item.data.face;
        row_c  = (item.data.row > s_eff) ? s_eff : item.data.row;
        col_c  = (item.data.col > s_eff) ? s_eff : item.data.col;
    end

    assign item.ready = !v1_reg || !full;
    assign take       = item.valid && item.ready;
    assign push       = v1_reg && !full;

    // Stage one holds the clamped beat and face*(S+1)+row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (item.ready)
            v1_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg    <= s_eff;
            face1_reg <= face_c;
            row1_reg  <= row_c;
            col1_reg  <= col_c;
            fr1_reg   <= FR_W'(FR_W'(face_c) * FR_W'({1'b0, s_eff} + 1'b1) + FR_W'(row_c));
        end
    end

    // Stage two: face vector, squared length and neighbour indices.
    always_comb
    begin
        logic signed [S_W+1:0]  p, q;
        logic [MAG_W-1:0]       mp, mq;
        logic                   np, nq;
        logic [LEN_W-1:0]       len2;
        logic [BASE_W-1:0]      base;
        logic [S_W:0]           s1p;
        logic                   quad;
        p    = $signed({1'b0, row1_reg, 1'b0}) - $signed({2'b00, s1_reg});
        q    = $signed({1'b0, col1_reg, 1'b0}) - $signed({2'b00, s1_reg});
        np   = p[S_W+1];
        nq   = q[S_W+1];
        mp   = MAG_W'(np ? -p : p);
        mq   = MAG_W'(nq ? -q : q);
        len2 = LEN_W'(mp * mp) + LEN_W'(mq * mq) + LEN_W'(s1_reg * s1_reg);
        s1p  = {1'b0, s1_reg} + 1'b1;
        base = BASE_W'(fr1_reg * s1p) + BASE_W'(col1_reg);
        quad = (row1_reg < s1_reg) && (col1_reg < s1_reg);

        push_data.mag  = {mq, mp, mp};
        push_data.meta.neg = {nq, np, np};
        case (face1_reg)
            FACE_POS_X:
            begin
                push_data.mag      = {mq, mp, s1_reg};
                push_data.meta.neg = {nq, np, 1'b0};
            end
            FACE_NEG_X:
            begin
                push_data.mag      = {mq, mp, s1_reg};
                push_data.meta.neg = {nq, np, 1'b1};
            end
            FACE_NEG_Y:
            begin
                push_data.mag      = {mq, s1_reg, mp};
                push_data.meta.neg = {nq, 1'b1, np};
            end
            FACE_POS_Y:
            begin
                push_data.mag      = {mq, s1_reg, mp};
                push_data.meta.neg = {nq, 1'b0, np};
            end
            FACE_POS_Z:
            begin
                push_data.mag      = {s1_reg, mq, mp};
                push_data.meta.neg = {1'b0, nq, np};
            end
            default:
            begin
                push_data.mag      = {s1_reg, mq, mp};
                push_data.meta.neg = {1'b1, nq, np};
            end
        endcase
        push_data.meta.len2           = len2;
        push_data.meta.base_index     = IDX_W'(base);
        push_data.meta.below_index    = quad ? IDX_W'(base + BASE_W'(s1p)) : '0;
        push_data.meta.right_index    = quad ? IDX_W'(base + 1'b1) : '0;
        push_data.meta.diagonal_index = quad ? IDX_W'(base + BASE_W'(s1p) + 1'b1) : '0;
        push_data.meta.quad_valid     = quad;
    end
endmodule

@@ rtl/csv_back.sv @@
// Back end: pipelined square-root normaliser, one root bit per stage, and output register.
// Depends on csv_pkg, csv_stream_if and the assertion macros header.
`include "cube_sphere_vertex_generator_unit_defines.svh"

module csv_back (
    input  logic                clk,
    input  logic                rst_n,
    output logic                pop,
    input  csv_pkg::csv_work_t  pop_data,
    input  logic                empty,
    csv_stream_if.source        result
);
    import csv_pkg::*;

    csv_stage_t stage_reg [W_W+1];
    logic       vld_reg   [W_W+1];
    csv_out_t   out_reg;
    logic       out_v_reg;
    logic       en;

    // The whole pipeline moves unless the output beat is stalled.
    assign en           = !out_v_reg || result.ready;
    assign pop          = en && !empty;
    assign result.valid = out_v_reg;
    assign result.data  = out_reg;

    // Entry stage: remainder starts at a*a shifted up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= !empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int c = 0; c < 3; c++)
            begin
                stage_reg[0].acc[c].rem <= REM_W'(pop_data.mag[c] * pop_data.mag[c]) << SHIFT;
                stage_reg[0].acc[c].m   <= '0;
                stage_reg[0].acc[c].w   <= '0;
            end
            stage_reg[0].meta <= pop_data.meta;
        end
    end

    // Root stages, from the top bit of w down.
    for (genvar k = 0; k < W_W; k++)
    begin : g_root
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en && vld_reg[k])
            begin
                for (int c = 0; c < 3; c++)
                    stage_reg[k+1].acc[c] <= csv_root_step(stage_reg[k].acc[c],
                        stage_reg[k].meta.len2, (W_W - 1 - k));
                stage_reg[k+1].meta <= stage_reg[k].meta;
            end
        end
    end

    // Output register: rounding, sign and saturation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= vld_reg[W_W];
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[W_W])
        begin
            out_reg.pos_x <= csv_to_coord(stage_reg[W_W].acc[0].w, stage_reg[W_W].meta.neg[0]);
            out_reg.pos_y <= csv_to_coord(stage_reg[W_W].acc[1].w, stage_reg[W_W].meta.neg[1]);
            out_reg.pos_z <= csv_to_coord(stage_reg[W_W].acc[2].w, stage_reg[W_W].meta.neg[2]);
            out_reg.base_index     <= stage_reg[W_W].meta.base_index;
            out_reg.below_index    <= stage_reg[W_W].meta.below_index;
            out_reg.right_index    <= stage_reg[W_W].meta.right_index;
            out_reg.diagonal_index <= stage_reg[W_W].meta.diagonal_index;
            out_reg.quad_valid     <= stage_reg[W_W].meta.quad_valid;
        end
    end

    `CSV_ASSERT_IMPLIES(a_no_quad_zero, clk, rst_n, out_v_reg && !out_reg.quad_valid, out_reg.below_index == '0 && out_reg.right_index == '0 && out_reg.diagonal_index == '0, "neighbour index set without a quad")
endmodule

@@ verif/csv_tb_if.sv @@
// Testbench-side note: the channels come from the RTL interface csv_stream_if.
// Holds a small helper package for the testbench; depends on csv_pkg.
`timescale 1ns / 100ps
package csv_tb_pkg;
    import csv_pkg::*;

    // Sender and receiver idle percentages for one phase of the run.
    typedef struct {
        int unsigned src_idle;
        int unsigned snk_idle;
    } idle_mix_t;
endpackage

@@ verif/tb_top.sv @@
// Testbench for the cube-sphere vertex generator: predicts every vertex with
// exact integer arithmetic and checks the result beats in order.
// Depends on csv_pkg, csv_stream_if, csv_tb_pkg and the generator RTL.
`timescale 1ns / 100ps
module tb_top;
    import csv_pkg::*;
    import csv_tb_pkg::*;

    localparam int MAX_S = 256;
    localparam longint LIMIT = 400000;

    // Holds the expected vertices and the subdivision setting they depend on.
    class vertex_scoreboard;
        csv_out_t  pending[$];
        int unsigned s_reg;
        int unsigned errors;
        int unsigned checked;

        function new();
            s_reg = 16;
            errors = 0;
            checked = 0;
        endfunction

        // Rounded magnitude of a*2^15/sqrt(len2), by bisection on exact squares.
        function automatic int unsigned unit_mag(longint unsigned a, longint unsigned len2);
            longint unsigned lo, hi, mid, t, lhs, q;
            lo = 0;
            hi = 32768;
            if (a == 0)
                return 0;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                t = 2 * mid - 1;
                lhs = t * t * len2;
                q = (lhs >> 32) + ((lhs[31:0] != 0) ? 1 : 0);
                if (q <= a * a)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return 32'(lo);
        endfunction

        function automatic logic [15:0] coord(longint c, longint unsigned len2);
            int unsigned r;
            r = unit_mag(c < 0 ? -c : c, len2);
            if (c >= 0)
                return (r > 32767) ? 16'h7fff : r[15:0];
            return 16'(65536 - r);
        endfunction

        // Notes an accepted input beat and queues its vertex.
        function void note_item(csv_in_t it);
            longint s, f, rw, cl, p, q, vx, vy, vz;
            longint unsigned len2, base;
            csv_out_t o;
            s = (s_reg == 0) ? 1 : (s_reg > MAX_S ? MAX_S : s_reg);
            f = (it.face > FACE_NEG_Z) ? FACE_NEG_Z : it.face;
            rw = (it.row > s) ? s : it.row;
            cl = (it.col > s) ? s : it.col;
            p = 2 * rw - s;
            q = 2 * cl - s;
            case (csv_face_e'(f))
                FACE_POS_X: begin vx = s;  vy = p;  vz = q;  end
                FACE_NEG_X: begin vx = -s; vy = p;  vz = q;  end
                FACE_NEG_Y: begin vx = p;  vy = -s; vz = q;  end
                FACE_POS_Y: begin vx = p;  vy = s;  vz = q;  end
                FACE_POS_Z: begin vx = p;  vy = q;  vz = s;  end
                default:    begin vx = p;  vy = q;  vz = -s; end
            endcase
            len2 = p * p + q * q + s * s;
            o.pos_x = coord(vx, len2);
            o.pos_y = coord(vy, len2);
            o.pos_z = coord(vz, len2);
            base = (f * (s + 1) + rw) * (s + 1) + cl;
            o.quad_valid = (rw < s) && (cl < s);
            o.base_index = base[18:0];
            o.below_index = o.quad_valid ? 19'(base + s + 1) : '0;
            o.right_index = o.quad_valid ? 19'(base + 1) : '0;
            o.diagonal_index = o.quad_valid ? 19'(base + s + 2) : '0;
            pending.insert(pending.size(), o);
        endfunction

        // Compares one result beat with the oldest expected vertex.
        function void check_result(csv_out_t got);
            csv_out_t exp_v;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_v = pending.pop_front();
            checked++;
            if (got.pos_x !== exp_v.pos_x)
                $display("%0t: pos_x exp %0d got %0d", $time, exp_v.pos_x, got.pos_x);
            if (got.pos_y !== exp_v.pos_y)
                $display("%0t: pos_y exp %0d got %0d", $time, exp_v.pos_y, got.pos_y);
            if (got.pos_z !== exp_v.pos_z)
                $display("%0t: pos_z exp %0d got %0d", $time, exp_v.pos_z, got.pos_z);
            if (got.base_index !== exp_v.base_index)
                $display("%0t: base_index exp %0d got %0d", $time, exp_v.base_index,
                         got.base_index);
            if (got.below_index !== exp_v.below_index)
                $display("%0t: below_index exp %0d got %0d", $time, exp_v.below_index,
                         got.below_index);
            if (got.right_index !== exp_v.right_index)
                $display("%0t: right_index exp %0d got %0d", $time, exp_v.right_index,
                         got.right_index);
            if (got.diagonal_index !== exp_v.diagonal_index)
                $display("%0t: diagonal_index exp %0d got %0d", $time,
                         exp_v.diagonal_index, got.diagonal_index);
            if (got.quad_valid !== exp_v.quad_valid)
                $display("%0t: quad_valid exp %0d got %0d", $time, exp_v.quad_valid,
                         got.quad_valid);
            if (got !== exp_v)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    csv_stream_if #(.T(csv_in_t))  item_ch ();
    csv_stream_if #(.T(csv_cfg_t)) cfg_ch ();
    csv_stream_if #(.T(csv_out_t)) result_ch ();

    vertex_scoreboard vsb;
    idle_mix_t mix;
    longint cycles = 0;
    int unsigned hold_cycles;
    int unsigned hold_req = 0;
    int unsigned hold_seen;
    int unsigned items_sent;

    cube_sphere_vertex_generator_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .cfg    (cfg_ch.sink),
        .result (result_ch.source)
    );

    // Clock and cycle limit.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_cycles <= 0;
            hold_seen <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
                vsb.check_result(result_ch.data);
            if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_cycles <= 200;
                result_ch.ready <= 1'b0;
            end
            else if (hold_cycles != 0)
            begin
                hold_cycles <= hold_cycles - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= mix.snk_idle);
        end
    end

    // Sends one input beat, idling at random first.
    task automatic send_item(logic [2:0] f, logic [8:0] r, logic [8:0] c);
        csv_in_t it;
        it.face = f;
        it.row = r;
        it.col = c;
        while ($urandom_range(99) < mix.src_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
        vsb.note_item(it);
        items_sent++;
    endtask

    // Waits until every expected vertex has arrived, then lets the pipe drain.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (vsb.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Writes the subdivision register while the block is idle.
    task automatic write_subdiv(logic [8:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        vsb.s_reg = 32'(value);
    endtask

    // Random point: mostly in range, with clamped rows, columns and faces too.
    task automatic random_item();
        int unsigned s;
        s = (vsb.s_reg == 0) ? 1 : (vsb.s_reg > MAX_S ? MAX_S : vsb.s_reg);
        if ($urandom_range(9) < 8)
            send_item(3'($urandom_range(5)), 9'($urandom_range(s)), 9'($urandom_range(s)));
        else
            send_item(3'($urandom_range(7)), 9'($urandom_range(511)),
                      9'($urandom_range(511)));
    endtask

    initial
    begin
        logic [8:0] settings[8];
        vsb = new();
        items_sent = 0;
        mix.src_idle = 38;
        mix.snk_idle = 83;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners, centre, clamping and faces six and seven at reset size.
        for (int f = 0; f < 8; f++)
            send_item(3'(f), 9'd0, 9'd0);
        send_item(FACE_POS_X, 9'd16, 9'd16);
        send_item(FACE_POS_Z, 9'd8, 9'd8);
        send_item(FACE_NEG_Y, 9'd15, 9'd15);
        send_item(FACE_POS_Y, 9'd511, 9'd0);
        send_item(FACE_NEG_X, 9'd0, 9'd511);
        send_item(FACE_NEG_Z, 9'd300, 9'd257);
        drain();

        // Extremes of the register: zero, which clamps to one, and 511, which clamps to the maximum.
        write_subdiv(9'd0);
        send_item(FACE_POS_X, 9'd0, 9'd1);
        send_item(FACE_NEG_Z, 9'd1, 9'd1);
        drain();
        write_subdiv(9'd511);
        send_item(FACE_NEG_Z, 9'd255, 9'd255);
        send_item(FACE_POS_Y, 9'd256, 9'd128);
        send_item(FACE_NEG_X, 9'd128, 9'd128);
        drain();

        // Random phases across several settings and idle mixes.
        settings = '{1, 2, 3, 7, 16, 100, 256, 300};
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
            begin
                mix.src_idle = 83;
                mix.snk_idle = 38;
            end
            if (ph == 6)
            begin
                mix.src_idle = 0;
                mix.snk_idle = 0;
            end
            write_subdiv(settings[ph]);
            if (ph == 6)
                hold_req++;
            for (int k = 0; k < 86; k++)
                random_item();
            drain();
        end

        $display("Sent %0d grid points and checked %0d vertices over ten subdivision",
                 items_sent, vsb.checked);
        $display("settings, including zero, one, the maximum and beyond it.");
        if (vsb.errors == 0 && vsb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/csv_pkg.sv
rtl/csv_stream_if.sv
rtl/csv_fifo.sv
rtl/csv_front.sv
rtl/csv_back.sv
rtl/cube_sphere_vertex_generator_unit.sv
verif/csv_tb_if.sv
verif/tb_top.sv
